// ===== rtl/weighted_edit_distance_best_match_defines.svh =====
// Assertion macros used by the checker module of this block.
`ifndef WEIGHTED_EDIT_DISTANCE_BEST_MATCH_DEFINES_SVH
`define WEIGHTED_EDIT_DISTANCE_BEST_MATCH_DEFINES_SVH

// Concurrent assertion that is checked outside reset.
`define WEDBM_ASSERT(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

// Concurrent assertion that is checked on every edge, reset included.
`define WEDBM_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/wedbm_pkg.sv =====
package wedbm_pkg;

  localparam int CLS_W      = 8;
  localparam int NUM_CLASSES = 2 ** CLS_W;
  localparam int MAX_LEN    = 32;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int REC_AW     = $clog2(MAX_LEN);
  localparam int MAX_CANDS  = 1024;
  localparam int CAND_W     = $clog2(MAX_CANDS);
  localparam int DIST_W     = 15;
  localparam int COST_W     = 9;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int COST_AW    = 2 * CLS_W;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [COST_W-1:0] UNIT_COST = COST_W'(256);

  localparam logic [DIST_W-1:0] ACCEPT_RESET = DIST_W'(256);
  localparam logic [DIST_W-1:0] MARGIN_RESET = '0;
  localparam logic [CLS_W-1:0]  BLANK_RESET  = CLS_W'(255);

  localparam logic [1:0] FUNC_COST = 2'd0;
  localparam logic [1:0] FUNC_REC  = 2'd1;
  localparam logic [1:0] FUNC_CAND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd2;

  typedef struct packed {
    logic accept_cost;
    logic accept_rec;
    logic accept_cand;
    logic issue;
    logic rebuild;
    logic clear_idx;
    logic update_best;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic cand_ends;
  } status_t;

  // Saturating add of two distances; both operands stay below 2**DIST_W.
  function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] a,
                                                logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

// ===== rtl/wedbm_ram.sv =====
module wedbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wedbm_ctrl.sv =====
module wedbm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         func,
  input  wedbm_pkg::status_t status,
  output wedbm_pkg::cmd_t    cmd,
  output logic               busy
);

  typedef enum logic [6:0] {
    IDLE  = 7'b0000001,
    CAND  = 7'b0000010,
    CWAIT = 7'b0000100,
    FIN   = 7'b0001000,
    REP   = 7'b0010000,
    REB   = 7'b0100000,
    RWAIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          unique case (func)
            wedbm_pkg::FUNC_COST: cmd.accept_cost = 1'b1;
            wedbm_pkg::FUNC_REC: begin
              cmd.accept_rec = 1'b1;
              cmd.clear_idx  = 1'b1;
              state_next     = REB;
            end
            wedbm_pkg::FUNC_CAND: begin
              cmd.accept_cand = 1'b1;
              cmd.clear_idx   = 1'b1;
              state_next      = CAND;
            end
            default: ;
          endcase
        end
      end
      CAND: begin
        cmd.issue = 1'b1;
        if (status.idx_last) begin
          state_next = CWAIT;
        end
      end
      CWAIT: begin
        state_next = status.cand_ends ? FIN : IDLE;
      end
      FIN: begin
        cmd.update_best = 1'b1;
        state_next = REP;
      end
      REP: begin
        cmd.report    = 1'b1;
        cmd.clear_idx = 1'b1;
        state_next    = REB;
      end
      REB: begin
        cmd.issue   = 1'b1;
        cmd.rebuild = 1'b1;
        if (status.idx_last) begin
          state_next = RWAIT;
        end
      end
      RWAIT: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

endmodule

// ===== rtl/wedbm_dp.sv =====
module wedbm_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wedbm_pkg::cmd_t                       cmd,
  output wedbm_pkg::status_t                    status,
  input  logic                                  cfg_write,
  input  logic [wedbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wedbm_pkg::CFG_W-1:0]           cfg_data,
  input  logic [wedbm_pkg::CLS_W-1:0]           sym_a,
  input  logic [wedbm_pkg::CLS_W-1:0]           sym_b,
  input  logic [wedbm_pkg::COST_W-1:0]          cost_value,
  input  logic                                  ends_string,
  input  logic                                  ends_list,
  output logic                                  done,
  output logic [wedbm_pkg::CAND_W-1:0]          cand_index,
  output logic [wedbm_pkg::DIST_W-1:0]          cand_distance,
  output logic [wedbm_pkg::CAND_W-1:0]          best_index,
  output logic [wedbm_pkg::DIST_W-1:0]          best_distance,
  output logic [wedbm_pkg::DIST_W-1:0]          second_distance,
  output logic                                  list_done,
  output logic                                  accepted
);

  localparam int CLS_W  = wedbm_pkg::CLS_W;
  localparam int LEN_W  = wedbm_pkg::LEN_W;
  localparam int DIST_W = wedbm_pkg::DIST_W;
  localparam int COST_W = wedbm_pkg::COST_W;
  localparam int CAND_W = wedbm_pkg::CAND_W;

  // Configuration registers.
  logic [DIST_W-1:0] accept_thr, margin_thr;
  logic [CLS_W-1:0]  blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_thr <= wedbm_pkg::ACCEPT_RESET;
      margin_thr <= wedbm_pkg::MARGIN_RESET;
      blank      <= wedbm_pkg::BLANK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wedbm_pkg::CFG_ACCEPT: accept_thr <= cfg_data[DIST_W-1:0];
        wedbm_pkg::CFG_MARGIN: margin_thr <= cfg_data[DIST_W-1:0];
        wedbm_pkg::CFG_BLANK:  blank      <= cfg_data[CLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Recognized string.
  logic [CLS_W-1:0] rec_sym [wedbm_pkg::MAX_LEN];
  logic [LEN_W-1:0] rec_len, rec_base;
  logic             rec_complete;

  assign rec_base = rec_complete ? '0 : rec_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_len      <= '0;
      rec_complete <= 1'b0;
    end else if (cmd.accept_rec) begin
      rec_complete <= ends_string;
      if (rec_base < LEN_W'(wedbm_pkg::MAX_LEN)) begin
        rec_len <= rec_base + 1'b1;
      end else begin
        rec_len <= rec_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_rec && rec_base < LEN_W'(wedbm_pkg::MAX_LEN)) begin
      rec_sym[rec_base[wedbm_pkg::REC_AW-1:0]] <= sym_a;
    end
  end

  // Candidate item fields.
  logic [CLS_W-1:0] cand_sym;
  logic             cand_es, cand_el;

  always_ff @(posedge clk) begin
    if (cmd.accept_cand) begin
      cand_sym <= sym_a;
      cand_es  <= ends_string;
      cand_el  <= ends_list;
    end
  end

  // Cell issue counter.
  logic [LEN_W-1:0]                idx, idx_m1;
  logic [CLS_W-1:0]                row_sym;
  logic [wedbm_pkg::COST_AW-1:0]   addr_sub, addr_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clear_idx) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + 1'b1;
    end
  end

  assign idx_m1   = idx - 1'b1;
  assign row_sym  = rec_sym[idx_m1[wedbm_pkg::REC_AW-1:0]];
  assign addr_sub = (idx == '0) ? {blank, cand_sym} : {row_sym, cand_sym};
  assign addr_ins = {row_sym, blank};

  assign status.idx_last  = (idx == rec_len);
  assign status.cand_ends = cand_es | cand_el;

  // Cost table, two copies for two reads per cell.
  logic [COST_W-1:0] sub_raw, ins_raw;

  wedbm_ram #(.WIDTH(COST_W), .DEPTH(2 ** wedbm_pkg::COST_AW)) u_cost_sub (
    .clk(clk), .we(cmd.accept_cost), .waddr({sym_a, sym_b}), .wdata(cost_value),
    .raddr(addr_sub), .rdata(sub_raw)
  );

  wedbm_ram #(.WIDTH(COST_W), .DEPTH(2 ** wedbm_pkg::COST_AW)) u_cost_ins (
    .clk(clk), .we(cmd.accept_cost), .waddr({sym_a, sym_b}), .wdata(cost_value),
    .raddr(addr_ins), .rdata(ins_raw)
  );

  // Cell compute stage.
  logic             p_valid, p_rebuild, p_row0, p_sub_zero, p_ins_unit, p_c_blank;
  logic [LEN_W-1:0] p_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    p_idx      <= idx;
    p_rebuild  <= cmd.rebuild;
    p_row0     <= (idx == '0);
    p_sub_zero <= (idx == '0) ? (blank == cand_sym) : (row_sym == cand_sym);
    p_ins_unit <= (row_sym == blank);
    p_c_blank  <= (cand_sym == blank);
  end

  logic [DIST_W-1:0] old_val, old_cell, above, diag, del_cost;
  logic [DIST_W-1:0] sub_c, ins_c, via_ins, via_del, via_sub, m_min, m;
  logic              col_fresh;

  wedbm_ram #(.WIDTH(DIST_W), .DEPTH(wedbm_pkg::MAX_LEN + 1)) u_column (
    .clk(clk), .we(p_valid), .waddr(p_idx), .wdata(m),
    .raddr(idx), .rdata(old_val)
  );

  // The column store has no reset. Until cell 0 is first written it reads as
  // zero, the prefix cost of the empty string.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_fresh <= 1'b1;
    end else if (p_valid && p_row0) begin
      col_fresh <= 1'b0;
    end
  end

  assign old_cell = (p_row0 && col_fresh) ? '0 : old_val;

  assign sub_c   = p_sub_zero ? '0 : DIST_W'(sub_raw);
  assign ins_c   = DIST_W'(p_ins_unit ? wedbm_pkg::UNIT_COST : ins_raw);
  assign via_ins = wedbm_pkg::sat_add(above, ins_c);
  assign via_del = wedbm_pkg::sat_add(old_cell, del_cost);
  assign via_sub = wedbm_pkg::sat_add(diag, sub_c);
  assign m_min   = (via_del < via_ins) ? via_del : via_ins;

  always_comb begin
    if (p_rebuild) begin
      m = p_row0 ? '0 : via_ins;
    end else if (p_row0) begin
      m = wedbm_pkg::sat_add(old_cell, sub_c);
    end else begin
      m = (via_sub < m_min) ? via_sub : m_min;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      above <= m;
      diag  <= old_cell;
      if (p_row0) begin
        del_cost <= DIST_W'(p_c_blank ? wedbm_pkg::UNIT_COST : sub_raw);
      end
    end
  end

  // Running best, second best and candidate counter.
  logic [CAND_W-1:0] cand_cnt, best_idx;
  logic [DIST_W-1:0] best_dist, second_dist;
  logic              list_clear;

  assign list_clear = cmd.accept_rec || (cmd.report && cand_el);

  always_ff @(posedge clk) begin
    if (rst || list_clear) begin
      cand_cnt    <= '0;
      best_idx    <= '0;
      best_dist   <= wedbm_pkg::DIST_MAX;
      second_dist <= wedbm_pkg::DIST_MAX;
    end else if (cmd.update_best) begin
      if (above < best_dist) begin
        second_dist <= best_dist;
        best_dist   <= above;
        best_idx    <= cand_cnt;
      end else if (above < second_dist) begin
        second_dist <= above;
      end
    end else if (cmd.report) begin
      cand_cnt <= cand_cnt + 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      cand_index      <= cand_cnt;
      cand_distance   <= above;
      best_index      <= best_idx;
      best_distance   <= best_dist;
      second_distance <= second_dist;
      list_done       <= cand_el;
      accepted        <= cand_el && (best_dist <= accept_thr) &&
                         ((second_dist - best_dist) >= margin_thr);
    end
  end

endmodule

// ===== rtl/weighted_edit_distance_best_match.sv =====
// Channel     Handshake                 Payload
// input item  start & !busy             func, sym_a, sym_b, cost_value, ends_string, ends_list
// result      done (one cycle)          cand_index, cand_distance, best_index, best_distance,
//                                       second_distance, list_done, accepted
// config      cfg_write                 cfg_index, cfg_data
//
// A cost write item leaves busy low. A recognized symbol item appends to the stored
// string and then rebuilds the column through the states REB and RWAIT. A candidate
// symbol item steps through CAND and CWAIT, and, when it ends a candidate, on through
// FIN, REP, REB and RWAIT; one cell of the column is computed per cycle by a single
// add/min unit fed by two copies of the cost table. Reset is synchronous and active high.
// Results cannot be stalled: done is high for exactly one cycle per finished candidate.
module weighted_edit_distance_best_match (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic [wedbm_pkg::CLS_W-1:0]        sym_a,
  input  logic [wedbm_pkg::CLS_W-1:0]        sym_b,
  input  logic [wedbm_pkg::COST_W-1:0]       cost_value,
  input  logic                               ends_string,
  input  logic                               ends_list,
  input  logic                               cfg_write,
  input  logic [wedbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wedbm_pkg::CFG_W-1:0]        cfg_data,
  output logic                               done,
  output logic [wedbm_pkg::CAND_W-1:0]       cand_index,
  output logic [wedbm_pkg::DIST_W-1:0]       cand_distance,
  output logic [wedbm_pkg::CAND_W-1:0]       best_index,
  output logic [wedbm_pkg::DIST_W-1:0]       best_distance,
  output logic [wedbm_pkg::DIST_W-1:0]       second_distance,
  output logic                               list_done,
  output logic                               accepted
);

  // The controller sequences each item; the datapath holds the string, the
  // dynamic-programming column, the cost table and the running best results.
  wedbm_pkg::cmd_t    cmd;
  wedbm_pkg::status_t status;

  wedbm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .status(status), .cmd(cmd), .busy(busy)
  );

  wedbm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sym_a(sym_a), .sym_b(sym_b), .cost_value(cost_value),
    .ends_string(ends_string), .ends_list(ends_list),
    .done(done), .cand_index(cand_index), .cand_distance(cand_distance),
    .best_index(best_index), .best_distance(best_distance),
    .second_distance(second_distance), .list_done(list_done), .accepted(accepted)
  );

endmodule

// ===== rtl/wedbm_checker.sv =====
`include "weighted_edit_distance_best_match_defines.svh"

module wedbm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        func,
  input logic                              done,
  input logic [wedbm_pkg::DIST_W-1:0]      best_distance,
  input logic [wedbm_pkg::DIST_W-1:0]      second_distance,
  input logic                              list_done,
  input logic                              accepted
);

  // A result is shown while the block rebuilds its column.
  `WEDBM_ASSERT(a_done_busy, clk, rst, done |-> busy, "result outside a busy period")
  // The decision is only given on the last candidate.
  `WEDBM_ASSERT(a_acc_last, clk, rst, done && accepted |-> list_done, "accept without list end")
  // Best never exceeds second best.
  `WEDBM_ASSERT(a_order, clk, rst, done |-> best_distance <= second_distance,
    "best above second best")
  // A candidate symbol always makes the block busy.
  `WEDBM_ASSERT(a_cand_busy, clk, rst,
    start && !busy && func == wedbm_pkg::FUNC_CAND |=> busy, "candidate item not taken")
  // No result directly after reset.
  `WEDBM_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !done, "result after reset")

endmodule

bind weighted_edit_distance_best_match wedbm_checker u_wedbm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .done(done),
  .best_distance(best_distance), .second_distance(second_distance),
  .list_done(list_done), .accepted(accepted)
);
